@@ rtl/core/fbcrd_pkg.sv @@
// fbcrd_pkg: shared types and constants for the fsk bit clock recovery and descrambler
// no dependencies; imported by every module under rtl/core
`default_nettype none

package fbcrd_pkg;

    // field and state widths fixed by the item layout
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 16;
    localparam int INC_W    = 15;

    // phase_increment after reset
    localparam logic [INC_W-1:0] INC_RESET = 15'd9511;

    // phase midpoint
    localparam logic [PHASE_W:0] PHASE_MID = 17'h08000;

    // default descrambler taps (g3ruh polynomial)
    localparam int TAP_FIRST_DEF  = 0;
    localparam int TAP_SECOND_DEF = 12;
    localparam int TAP_LAST_DEF   = 17;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_PHASE_INC = 1'b0;

    // output of the bit clock tracker for one sample
    typedef struct packed {
        logic wrap;
        logic level;
    } clk_result_t;

endpackage : fbcrd_pkg

`default_nettype wire

@@ rtl/core/fbcrd_phase_track.sv @@
// fbcrd_phase_track: sign slicer and 16-bit bit clock phase with edge nudging
// depends on fbcrd_pkg
`default_nettype none

module fbcrd_phase_track (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           advance,
    input  wire logic [fbcrd_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [fbcrd_pkg::INC_W-1:0]    phase_inc,
    output fbcrd_pkg::clk_result_t              result
);
    import fbcrd_pkg::*;

    logic               prev_sign_reg, prev_sign_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               level;
    logic [PHASE_W:0]   threshold;
    logic [PHASE_W:0]   nudged;
    logic [PHASE_W:0]   advanced;
    logic [PHASE_W:0]   inc_ext;
    logic [PHASE_W:0]   eighth_ext;

    // slice: positive means sign clear and nonzero
    assign level = ~sample[SAMPLE_W-1] && (sample != '0);

    assign inc_ext    = {{(PHASE_W+1-INC_W){1'b0}}, phase_inc};
    assign eighth_ext = {{(PHASE_W+4-INC_W){1'b0}}, phase_inc[INC_W-1:3]};
    assign threshold  = PHASE_MID - {{(PHASE_W+2-INC_W){1'b0}}, phase_inc[INC_W-1:1]};

    // nudge on a level change, then advance by the increment
    always_comb begin
        nudged = {1'b0, phase_reg};
        if (level != prev_sign_reg) begin
            if ({1'b0, phase_reg} < threshold) begin
                nudged = {1'b0, phase_reg} + eighth_ext;
            end else begin
                nudged = {1'b0, phase_reg} - eighth_ext;
            end
        end
        advanced       = nudged + inc_ext;
        phase_next     = advanced[PHASE_W-1:0];
        prev_sign_next = level;
        result.wrap    = advanced[PHASE_W];
        result.level   = level;
    end

    // tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sign_reg <= 1'b0;
            phase_reg     <= '0;
        end else if (advance) begin
            prev_sign_reg <= prev_sign_next;
            phase_reg     <= phase_next;
        end
    end

endmodule : fbcrd_phase_track

`default_nettype wire

@@ rtl/core/fbcrd_descrambler.sv @@
// fbcrd_descrambler: nrzi decode and multiplicative descrambler over the line bit history
// depends on fbcrd_pkg (import only for house consistency of types)
`default_nettype none

module fbcrd_descrambler #(
    parameter int TAP_FIRST  = fbcrd_pkg::TAP_FIRST_DEF,
    parameter int TAP_SECOND = fbcrd_pkg::TAP_SECOND_DEF,
    parameter int TAP_LAST   = fbcrd_pkg::TAP_LAST_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire fbcrd_pkg::clk_result_t clk_in,
    input  wire logic advance,
    output logic      data_bit
);
    import fbcrd_pkg::*;

    localparam int HIST_W = TAP_LAST + 2;

    logic [HIST_W-1:0] hist_reg, hist_next;
    logic [HIST_W-1:0] diff;
    logic              take;

    assign take = advance && clk_in.wrap;

    // shift in the line bit, xor neighbors, xor the taps
    always_comb begin
        hist_next = {hist_reg[HIST_W-2:0], clk_in.level};
        diff      = hist_next ^ {1'b0, hist_next[HIST_W-1:1]};
        data_bit  = ~(diff[TAP_FIRST] ^ diff[TAP_SECOND] ^ diff[TAP_LAST]);
    end

    // history moves only when a bit is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (take) begin
            hist_reg <= hist_next;
        end
    end

endmodule : fbcrd_descrambler

`default_nettype wire

@@ rtl/core/fsk_bit_clock_recovery_descrambler_top.sv @@
// fsk_bit_clock_recovery_descrambler_top: stream ports, apb register, input and result registers
// depends on fbcrd_pkg, fbcrd_phase_track, fbcrd_descrambler
`default_nettype none

// Bit clock recovery and descrambler for 9600 baud FSK. Each sample item on the s_ stream is
// sliced by sign; a 16-bit bit clock phase advances by phase_increment per sample and is nudged
// by phase_increment/8 on each level change. On every phase wrap one result item leaves on the
// m_ stream with the descrambled data bit and the raw line bit; other samples give no item. The
// block takes one sample per cycle while s_tready is high: a sample is held in an input register,
// processed in one pass through the phase tracker and descrambler, and the result sits in an output
// register, so m_tvalid rises once the sample has passed the input register and then the output
// register. The sustained rate of one item per cycle, while the output is not stalled, is set by the
// phase update loop; the input stalls only while an item is held and a result waits in the output
// register with m_tready low. phase_increment is written through the apb port at address 0; the user
// must write it only while the stream is idle, and the block itself does not enforce this.
module fsk_bit_clock_recovery_descrambler_top #(
    parameter int TAP_FIRST  = fbcrd_pkg::TAP_FIRST_DEF,
    parameter int TAP_SECOND = fbcrd_pkg::TAP_SECOND_DEF,
    parameter int TAP_LAST   = fbcrd_pkg::TAP_LAST_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // apb configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [fbcrd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [fbcrd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [fbcrd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                  pready,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [15:0]                      s_tdata,  // [15:0] sample
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [7:0]                       m_tdata   // [0] data_bit, [1] line_bit
);
    import fbcrd_pkg::*;

    logic [INC_W-1:0]    phase_inc_reg;
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                out_valid_reg;
    logic                out_data_reg;
    logic                out_line_reg;
    logic                consume;
    logic                cfg_write;
    clk_result_t         clk_res;
    logic                data_bit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_inc_reg <= INC_RESET;
        end else if (cfg_write && (paddr[2] == REG_PHASE_INC)) begin
            phase_inc_reg <= pwdata[INC_W-1:0];
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_PHASE_INC) begin
            prdata = {{(APB_DATA_W-INC_W){1'b0}}, phase_inc_reg};
        end
    end

    // held item moves on when the output register is free or being emptied
    assign consume  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_sample_reg <= s_tdata;
        end
    end

    fbcrd_phase_track u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (consume),
        .sample    (in_sample_reg),
        .phase_inc (phase_inc_reg),
        .result    (clk_res)
    );

    fbcrd_descrambler #(
        .TAP_FIRST  (TAP_FIRST),
        .TAP_SECOND (TAP_SECOND),
        .TAP_LAST   (TAP_LAST)
    ) u_descr (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clk_in   (clk_res),
        .advance  (consume),
        .data_bit (data_bit)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= consume && clk_res.wrap;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && clk_res.wrap) begin
            out_data_reg <= data_bit;
            out_line_reg <= clk_res.level;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_line_reg, out_data_reg};

    // a new result only comes from a wrapping item
    a_result_from_wrap : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(consume && clk_res.wrap))
        else $error("result appeared without a phase wrap");

    // a stalled held item keeps its sample
    a_held_item_stable : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !consume) |=> (in_valid_reg && $stable(in_sample_reg)))
        else $error("held input item lost or changed");

    // input side stalls only while an item is held
    a_stall_only_when_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");

    // reset restores the default increment
    a_inc_reset : assert property (@(posedge aclk)
        $past(!aresetn) |-> (phase_inc_reg == INC_RESET))
        else $error("phase increment not reset");

endmodule : fsk_bit_clock_recovery_descrambler_top

`default_nettype wire

@@ tb/fbcrd_result_checker.sv @@
// fbcrd_result_checker: watches the apb port and both streams, predicts each result item
// depends on fbcrd_pkg; instantiated by testbench beside the block
`default_nettype none

module fbcrd_result_checker #(
    parameter int TAP_FIRST  = fbcrd_pkg::TAP_FIRST_DEF,
    parameter int TAP_SECOND = fbcrd_pkg::TAP_SECOND_DEF,
    parameter int TAP_LAST   = fbcrd_pkg::TAP_LAST_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [fbcrd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [fbcrd_pkg::APB_DATA_W-1:0] pwdata,
    input  wire logic [fbcrd_pkg::APB_DATA_W-1:0] prdata,
    input  wire logic                             pready,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [15:0]                      s_tdata,  // [15:0] sample
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [7:0]                       m_tdata,  // [0] data_bit, [1] line_bit
    output int                                    mismatch_count,
    output int                                    bits_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fbcrd_pkg::*;

    localparam int HIST_W = TAP_LAST + 2;
    localparam logic [APB_ADDR_W-1:0] PHASE_INC_ADDR = APB_ADDR_W'(4 * int'(REG_PHASE_INC));

    typedef struct packed {
        logic line_bit;
        logic data_bit;
    } bit_result_t;

    // predicted state of the bit clock and descrambler
    logic [INC_W-1:0]   inc_reg;
    logic               prev_level;
    logic [PHASE_W-1:0] clock_phase;
    logic [HIST_W-1:0]  history;
    bit_result_t        expected_bits[$];
    int                 mismatches;

    initial begin
        mismatches = 0;
    end

    task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected 0x%0h got 0x%0h", $realtime, what, exp_val, act_val);
    endtask

    // advance the bit clock by one sample, queue a result item on phase wrap
    task automatic recover_bit(input logic [15:0] sample);
        logic              level;
        logic [PHASE_W:0]  ph;
        logic [HIST_W-1:0] diff;
        bit_result_t       r;
        level = !sample[15] && (sample != 16'd0);
        ph = {1'b0, clock_phase};
        if (level != prev_level) begin
            if (ph < PHASE_MID - (PHASE_W+1)'(inc_reg >> 1))
                ph = ph + (PHASE_W+1)'(inc_reg >> 3);
            else
                ph = ph - (PHASE_W+1)'(inc_reg >> 3);
        end
        prev_level = level;
        ph = ph + (PHASE_W+1)'(inc_reg);
        clock_phase = ph[PHASE_W-1:0];
        if (ph[PHASE_W]) begin
            history = {history[HIST_W-2:0], level};
            diff = history ^ (history >> 1);
            r.data_bit = ~(diff[TAP_FIRST] ^ diff[TAP_SECOND] ^ diff[TAP_LAST]);
            r.line_bit = level;
            expected_bits.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        bit_result_t exp_r;
        if (!aresetn) begin
            inc_reg     = INC_RESET;
            prev_level  = 1'b0;
            clock_phase = '0;
            history     = '0;
            expected_bits.delete();
        end else begin
            // result items against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_bits.size() == 0) begin
                    note_mismatch("result item with none pending", 32'd0, 32'(m_tdata));
                end else begin
                    exp_r = expected_bits.pop_front();
                    if (m_tdata[0] !== exp_r.data_bit)
                        note_mismatch("data_bit", 32'(exp_r.data_bit), 32'(m_tdata[0]));
                    if (m_tdata[1] !== exp_r.line_bit)
                        note_mismatch("line_bit", 32'(exp_r.line_bit), 32'(m_tdata[1]));
                    if (m_tdata[7:2] !== 6'd0)
                        note_mismatch("tdata padding", 32'd0, 32'(m_tdata[7:2]));
                end
            end
            // sample items
            if (s_tvalid && s_tready)
                recover_bit(s_tdata);
            // register writes and read-back
            if (psel && penable && pready && paddr == PHASE_INC_ADDR) begin
                if (pwrite)
                    inc_reg = pwdata[INC_W-1:0];
                else if (prdata !== APB_DATA_W'(inc_reg))
                    note_mismatch("phase_increment read", APB_DATA_W'(inc_reg), prdata);
            end
        end
        bits_pending   <= expected_bits.size();
        mismatch_count <= mismatches;
    end

endmodule : fbcrd_result_checker

`default_nettype wire

@@ tb/testbench.sv @@
// testbench: clock, reset, apb writes and reads, sample stimulus with bursts and result stalls, verdict
// depends on fbcrd_pkg, fsk_bit_clock_recovery_descrambler_top, fbcrd_result_checker
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fbcrd_pkg::*;

    localparam logic [APB_ADDR_W-1:0] PHASE_INC_ADDR = APB_ADDR_W'(4 * int'(REG_PHASE_INC));
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 50000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    int                    mismatch_count;
    int                    bits_pending;

    // sender and symbol generator state
    int          burst_left = 0;
    logic        sym_level  = 1'b0;
    int          sym_left   = 0;
    int          sym_len    = 7;

    // receiver stall pattern state
    int          stall_mode = 0;
    int          stall_left = 0;
    int unsigned stall_tick = 0;

    fsk_bit_clock_recovery_descrambler_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fbcrd_result_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .bits_pending   (bits_pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver: modes of always ready, coin flip, mostly stalled and periodic
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (stall_tick % 5) != 0;
        endcase
        stall_tick <= stall_tick + 1;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // one sample item, with a random gap at the start of each burst
    task automatic send_item(input logic [15:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // stop sending and wait until every result item has left, plus pipeline slack
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bits_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_increment(input int unsigned inc);
        wait_drained();
        apb_access(1'b1, PHASE_INC_ADDR, APB_DATA_W'(inc));
        apb_access(1'b0, PHASE_INC_ADDR, '0);
        sym_len = (inc == 0) ? 8 : ((65536 / inc > 64) ? 64 : 65536 / inc);
        if (sym_len < 1)
            sym_len = 1;
    endtask

    // mostly symbol-shaped line signal near the bit rate, some noise and extremes
    task automatic make_sample(output logic [15:0] value);
        int unsigned pick;
        int          mag;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            value = 16'($urandom());
        end else if (pick < 12) begin
            case ($urandom_range(0, 4))
                0:       value = 16'h0000;
                1:       value = 16'h7fff;
                2:       value = 16'h8000;
                3:       value = 16'h0001;
                default: value = 16'hffff;
            endcase
        end else begin
            if (sym_left <= 0) begin
                sym_level = $urandom_range(0, 1);
                sym_left  = sym_len + $urandom_range(0, 2) - 1;
                if (sym_left < 1)
                    sym_left = 1;
            end
            sym_left--;
            if (sym_level) begin
                mag   = $urandom_range(1, 32767);
                value = 16'(mag);
            end else begin
                mag   = $urandom_range(1, 32768);
                value = 16'(-mag);
            end
        end
    endtask

    task automatic send_random(input int count);
        logic [15:0] value;
        repeat (count) begin
            make_sample(value);
            send_item(value);
        end
    endtask

    initial begin
        logic [15:0] directed[25];
        int unsigned phase_inc[6];
        int          phase_len[6];
        int          guard;

        // zero, smallest positive, extremes, then sign swings for both nudge directions
        directed = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000,
                     16'h0000, 16'h4000, 16'h4000, 16'hc000, 16'hc000,
                     16'h4000, 16'hc000, 16'h4000, 16'hc000, 16'h0000,
                     16'h0001, 16'h0000, 16'hffff, 16'h7fff, 16'h8000,
                     16'h2000, 16'h2000, 16'h2000, 16'he000, 16'h0000};
        phase_inc = '{32767, 1, 0, 9511, 2000, 16384};
        phase_len = '{150, 60, 20, 250, 120, 150};

        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset increment: directed items, random, a full drain, more random
        foreach (directed[i])
            send_item(directed[i]);
        send_random(300);
        wait_drained();
        send_random(150);

        // further increments, the extremes and zero among them
        foreach (phase_inc[i]) begin
            set_increment(phase_inc[i]);
            send_random(phase_len[i]);
        end
        set_increment($urandom_range(1, 32767));
        send_random(150);

        // drain and verdict
        s_tvalid <= 1'b0;
        @(posedge aclk);
        guard = 0;
        while (bits_pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES * 2) @(posedge aclk);
        if (mismatch_count == 0 && bits_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule : testbench

`default_nettype wire

@@ fsk_bit_clock_recovery_descrambler_top.f @@
rtl/core/fbcrd_pkg.sv
rtl/core/fbcrd_phase_track.sv
rtl/core/fbcrd_descrambler.sv
rtl/core/fsk_bit_clock_recovery_descrambler_top.sv
tb/fbcrd_result_checker.sv
tb/testbench.sv
